FILE: sv/cstr_pkg.sv
// shared types, constants and codes for the can transport segment/reassemble block
`default_nettype none
package cstr_pkg;

    localparam int REQ_BUF_DEPTH = 4096;
    localparam int ADDR_W        = $clog2(REQ_BUF_DEPTH);
    localparam int REQ_LIMIT     = (REQ_BUF_DEPTH < 4095) ? REQ_BUF_DEPTH : 4095;
    localparam int CFG_W         = 29;

    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_FRAME   = 2'd1;
    localparam logic [1:0] MODE_TXRDY   = 2'd2;
    localparam logic [1:0] MODE_TIMEOUT = 2'd3;

    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_BAD_FC    = 3'd2;
    localparam logic [2:0] ST_NO_RESP   = 3'd3;
    localparam logic [2:0] ST_UNDERSIZE = 3'd4;
    localparam logic [2:0] ST_SEQUENCE  = 3'd5;
    localparam logic [2:0] ST_UNKNOWN   = 3'd6;

    localparam logic [1:0] REG_TESTER_ID = 2'd0;
    localparam logic [1:0] REG_TARGET_ID = 2'd1;
    localparam logic [1:0] REG_SHORT_ACK = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        expect_response;
        logic [28:0] rx_id;
        logic [63:0] rx_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [28:0] tx_id;
        logic [3:0]  tx_dlc;
        logic [63:0] tx_data;
        logic [16:0] gap_us;
        logic [7:0]  payload_byte;
        logic        payload_end;
        logic [11:0] payload_length;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_STATUS = 3'd0,
        OP_SF     = 3'd1,
        OP_FF     = 3'd2,
        OP_CF     = 3'd3,
        OP_PAY    = 3'd4
    } t_op;

    // one job handed from the front to the back
    typedef struct packed {
        t_op         op;
        logic [2:0]  status;
        logic [11:0] len;
        logic [11:0] pos;
        logic [3:0]  seq;
        logic [2:0]  n;
        logic [16:0] gap;
        logic [63:0] data;
        logic [2:0]  first;
        logic        has_end;
        logic [2:0]  end_i;
        logic [11:0] plen;
        logic        ack;
        logic [3:0]  ack_dlc;
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

endpackage
`default_nettype wire

FILE: sv/can_transport_segment_reassemble.sv
// top level: can transport segmentation of a request and reassembly of its reply
//
//  channel  | direction | handshake                      | word
//  ---------+-----------+--------------------------------+-----------------------------
//  input    | in        | i_in_valid / o_in_stall        | t_in_item (mode, bytes, frame)
//  output   | out       | o_out_valid / i_out_stall      | t_out_item (frame, byte, status)
//  config   | in        | i_cfg_we, i_cfg_idx, i_cfg_data| register write, no read-back
//
//  an item is decoded by the front in the cycle it is accepted; the front takes
//  one item per cycle while the two-entry job queue has room
//  a frame built from stored request bytes passes through the back as a pop, one ram
//  read per byte (up to 7) through the single read port, the last read landing and
//  the emit; a reply pops its job, then gives one word per payload byte, and one
//  more for a flow-control acknowledge
//  request bytes are held off while earlier jobs may still read the buffer
//  synchronous active-low reset clears control state; the buffer needs no clearing
`default_nettype none
module can_transport_segment_reassemble (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire cstr_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output cstr_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [cstr_pkg::CFG_W-1:0] i_cfg_data
);
    import cstr_pkg::*;

    logic [28:0] r_tester_id, r_target_id;
    logic        r_short_ack;

    logic  push, pop, q_valid, q_full, back_idle;
    t_cmd  f_cmd, q_cmd;
    t_wr   wr;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tester_id <= '0;
            r_target_id <= '0;
            r_short_ack <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TESTER_ID: r_tester_id <= i_cfg_data;
                REG_TARGET_ID: r_target_id <= i_cfg_data;
                REG_SHORT_ACK: r_short_ack <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cstr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (i_in_item),
        // buffer busy while any job may still read it
        .i_busy      (q_valid || !back_idle),
        .i_q_full    (q_full),
        .i_target_id (r_target_id),
        .i_short_ack (r_short_ack),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_wr        (wr)
    );

    // request byte buffer
    cstr_ram #(
        .WIDTH (8),
        .DEPTH (REQ_BUF_DEPTH)
    ) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (wr.we),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cstr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    cstr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_idle      (back_idle),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .i_tester_id (r_tester_id),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_out_item)
    );
endmodule
`default_nettype wire

FILE: sv/cstr_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module cstr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/cstr_front.sv
// front: protocol phase tracking, request loading and job classification
`default_nettype none
module cstr_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire cstr_pkg::t_in_item i_item,
    input  wire logic             i_busy,
    input  wire logic             i_q_full,
    input  wire logic [28:0]      i_target_id,
    input  wire logic             i_short_ack,
    output logic                  o_push,
    output cstr_pkg::t_cmd        o_cmd,
    output cstr_pkg::t_wr         o_wr
);
    import cstr_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_WAIT_FC   = 5'b00010,
        PH_SENDING   = 5'b00100,
        PH_WAIT_RESP = 5'b01000,
        PH_RECV_CF   = 5'b10000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [12:0] r_count, n_count;
    logic [11:0] r_pos, n_pos;
    logic [3:0]  r_txseq, n_txseq, r_rxseq, n_rxseq;
    logic [11:0] r_rem, n_rem, r_total, n_total;
    logic [16:0] r_sep, n_sep;
    logic        r_wants, n_wants;
    logic [7:0]  r_svc, n_svc, r_byte0, n_byte0;

    logic        acc;
    logic [12:0] cnt_new;
    logic [7:0]  b0, b1, b2, b3;
    logic [11:0] flen, srem;
    logic [2:0]  ncf;
    logic [11:0] pos_new;

    assign o_in_stall = i_q_full || (i_item.mode == MODE_BYTE && i_busy);
    assign acc = i_in_valid && !o_in_stall;
    assign b0 = i_item.rx_data[63:56];
    assign b1 = i_item.rx_data[55:48];
    assign b2 = i_item.rx_data[47:40];
    assign b3 = i_item.rx_data[39:32];
    assign flen = {b0[3:0], b1};
    assign srem = r_count[11:0] - r_pos;
    assign ncf = (srem > 12'd7) ? 3'd7 : srem[2:0];
    assign pos_new = r_pos + {9'd0, ncf};

    always_comb begin
        n_phase = r_phase;  n_count = r_count;  n_pos = r_pos;
        n_txseq = r_txseq;  n_rxseq = r_rxseq;  n_rem = r_rem;  n_total = r_total;
        n_sep = r_sep;  n_wants = r_wants;  n_svc = r_svc;  n_byte0 = r_byte0;
        o_push = 1'b0;
        o_cmd = '0;
        o_wr = '0;
        cnt_new = r_count;
        if (acc) begin
            unique case (i_item.mode)
                MODE_BYTE: begin
                    if (r_phase == PH_IDLE) begin
                        if (r_count < 13'(REQ_LIMIT)) begin
                            o_wr.we = 1'b1;
                            o_wr.addr = r_count[ADDR_W-1:0];
                            o_wr.data = i_item.data_byte;
                            cnt_new = r_count + 13'd1;
                            if (r_count == 13'd0) begin
                                n_byte0 = i_item.data_byte;
                            end
                        end else begin
                            cnt_new = 13'(REQ_LIMIT + 1);
                        end
                        n_count = cnt_new;
                        if (i_item.last_byte) begin
                            o_push = 1'b1;
                            if (cnt_new > 13'(REQ_LIMIT)) begin
                                o_cmd.op = OP_STATUS;
                                o_cmd.status = ST_TOO_LONG;
                                n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                            end else begin
                                n_wants = i_item.expect_response;
                                n_svc = (r_count == 13'd0) ? i_item.data_byte : r_byte0;
                                o_cmd.len = cnt_new[11:0];
                                if (cnt_new < 13'd8) begin
                                    o_cmd.op = OP_SF;
                                    o_cmd.n = cnt_new[2:0];
                                    n_count = '0;  n_pos = '0;  n_rxseq = 4'd1;
                                    n_phase = i_item.expect_response ? PH_WAIT_RESP : PH_IDLE;
                                end else begin
                                    o_cmd.op = OP_FF;
                                    o_cmd.n = 3'd6;
                                    n_pos = 12'd6;
                                    n_txseq = 4'd1;
                                    n_phase = PH_WAIT_FC;
                                end
                            end
                        end
                    end
                end
                MODE_FRAME: begin
                    if (r_phase == PH_WAIT_FC && i_item.rx_id == i_target_id) begin
                        if ((b0 & 8'hf3) == 8'h31) begin
                            // wait frame: keep waiting
                        end else if ((b0 & 8'hf3) != 8'h30) begin
                            o_push = 1'b1;
                            o_cmd.op = OP_STATUS;
                            o_cmd.status = ST_BAD_FC;
                            n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                        end else begin
                            if (b2 < 8'h80) begin
                                n_sep = {10'd0, b2[6:0]} * 17'd1000;
                            end else if (b2 > 8'hf0 && b2 < 8'hfa) begin
                                n_sep = {13'd0, b2[3:0]} * 17'd100;
                            end else begin
                                n_sep = '0;
                            end
                            n_phase = PH_SENDING;
                        end
                    end else if (r_phase == PH_WAIT_RESP) begin
                        if (i_item.rx_id != i_target_id) begin
                            o_push = 1'b1;
                            o_cmd.op = OP_STATUS;
                            o_cmd.status = ST_NO_RESP;
                            n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                        end else if (b0 > 8'd0 && b0 < 8'd8) begin
                            // response pending replies are skipped
                            if (!(b0 > 8'd2 && b1 == 8'h7f && b2 == r_svc && b3 == 8'h78)) begin
                                o_push = 1'b1;
                                o_cmd.op = OP_PAY;
                                o_cmd.data = i_item.rx_data;
                                o_cmd.first = 3'd1;
                                o_cmd.n = b0[2:0];
                                o_cmd.has_end = 1'b1;
                                o_cmd.end_i = b0[2:0] - 3'd1;
                                o_cmd.plen = {4'd0, b0};
                                n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                            end
                        end else if (b0[7:4] == 4'h1) begin
                            o_push = 1'b1;
                            if (flen <= 12'd6) begin
                                o_cmd.op = OP_STATUS;
                                o_cmd.status = ST_UNDERSIZE;
                                n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                            end else begin
                                o_cmd.op = OP_PAY;
                                o_cmd.data = i_item.rx_data;
                                o_cmd.first = 3'd2;
                                o_cmd.n = 3'd6;
                                o_cmd.plen = flen;
                                o_cmd.ack = 1'b1;
                                o_cmd.ack_dlc = i_short_ack ? 4'd3 : 4'd8;
                                n_rem = flen - 12'd6;
                                n_total = flen;
                                n_rxseq = 4'd1;
                                n_phase = PH_RECV_CF;
                            end
                        end else begin
                            o_push = 1'b1;
                            o_cmd.op = OP_STATUS;
                            o_cmd.status = ST_UNKNOWN;
                            n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                        end
                    end else if (r_phase == PH_RECV_CF && i_item.rx_id == i_target_id) begin
                        o_push = 1'b1;
                        if (b0 != {4'h2, r_rxseq}) begin
                            o_cmd.op = OP_STATUS;
                            o_cmd.status = ST_SEQUENCE;
                            n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                        end else begin
                            o_cmd.op = OP_PAY;
                            o_cmd.data = i_item.rx_data;
                            o_cmd.first = 3'd1;
                            o_cmd.n = (r_rem > 12'd7) ? 3'd7 : r_rem[2:0];
                            o_cmd.has_end = (r_rem <= 12'd7);
                            o_cmd.end_i = r_rem[2:0] - 3'd1;
                            o_cmd.plen = r_total;
                            n_rem = r_rem - ((r_rem > 12'd7) ? 12'd7 : r_rem);
                            n_rxseq = r_rxseq + 4'd1;
                            if (r_rem <= 12'd7) begin
                                n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                            end
                        end
                    end
                end
                MODE_TXRDY: begin
                    if (r_phase == PH_SENDING) begin
                        o_push = 1'b1;
                        o_cmd.op = OP_CF;
                        o_cmd.seq = r_txseq;
                        o_cmd.pos = r_pos;
                        o_cmd.n = ncf;
                        n_txseq = r_txseq + 4'd1;
                        n_pos = pos_new;
                        if (pos_new < r_count[11:0]) begin
                            o_cmd.gap = r_sep;
                        end else begin
                            n_count = '0;  n_pos = '0;  n_rxseq = 4'd1;
                            n_phase = r_wants ? PH_WAIT_RESP : PH_IDLE;
                        end
                    end
                end
                MODE_TIMEOUT: begin
                    if (r_phase == PH_WAIT_FC) begin
                        o_push = 1'b1;
                        o_cmd.op = OP_STATUS;
                        o_cmd.status = ST_BAD_FC;
                        n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                    end else if (r_phase == PH_WAIT_RESP || r_phase == PH_RECV_CF) begin
                        o_push = 1'b1;
                        o_cmd.op = OP_STATUS;
                        o_cmd.status = ST_NO_RESP;
                        n_count = '0;  n_pos = '0;  n_phase = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;  r_count <= '0;  r_pos <= '0;
            r_txseq <= 4'd1;  r_rxseq <= 4'd1;  r_rem <= '0;  r_total <= '0;
            r_sep <= '0;  r_wants <= 1'b0;  r_svc <= '0;  r_byte0 <= '0;
        end else begin
            r_phase <= n_phase;  r_count <= n_count;  r_pos <= n_pos;
            r_txseq <= n_txseq;  r_rxseq <= n_rxseq;  r_rem <= n_rem;  r_total <= n_total;
            r_sep <= n_sep;  r_wants <= n_wants;  r_svc <= n_svc;  r_byte0 <= n_byte0;
        end
    end
endmodule
`default_nettype wire

FILE: sv/cstr_queue.sv
// two-entry job queue between front and back
`default_nettype none
module cstr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cstr_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_valid,
    output logic                o_full,
    output cstr_pkg::t_cmd      o_cmd
);
    import cstr_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;  r_rptr <= 1'b0;  r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

FILE: sv/cstr_back.sv
// back: gathers request bytes, builds frames and expands jobs into result words
`default_nettype none
module cstr_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    input  wire cstr_pkg::t_cmd            i_cmd,
    output logic                           o_pop,
    output logic                           o_idle,
    output logic [cstr_pkg::ADDR_W-1:0]    o_raddr,
    input  wire logic [7:0]                i_rdata,
    input  wire logic [28:0]               i_tester_id,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output cstr_pkg::t_out_item            o_result
);
    import cstr_pkg::*;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_READ  = 6'b000010,
        B_FRAME = 6'b000100,
        B_PAY   = 6'b001000,
        B_ACK   = 6'b010000,
        B_STAT  = 6'b100000
    } t_bstate;

    t_bstate     r_state, n_state;
    t_cmd        r_cmd;
    logic [2:0]  r_k, n_k;
    logic [63:0] r_frame, r_prev, init_frame;
    logic        r_rd_vld, rd_issue;
    logic [2:0]  r_rd_slot;
    logic        free, load;
    t_out_item   n_res;
    logic [2:0]  pidx;

    assign free = !o_out_valid || !i_out_stall;
    assign o_idle = (r_state == B_IDLE);
    assign pidx = r_cmd.first + r_k;
    assign o_raddr = ((r_cmd.op == OP_CF) ? r_cmd.pos[ADDR_W-1:0] : ADDR_W'(0))
                     + ADDR_W'(r_k);

    always_comb begin
        unique case (i_cmd.op)
            OP_SF:   init_frame = {i_cmd.len[7:0], 56'd0};
            OP_FF:   init_frame = {4'h1, i_cmd.len, 48'd0};
            OP_CF:   init_frame = {4'h2, i_cmd.seq, r_prev[55:0]};
            default: init_frame = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_k = r_k;
        o_pop = 1'b0;
        load = 1'b0;
        rd_issue = 1'b0;
        n_res = '0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_k = '0;
                    unique case (i_cmd.op)
                        OP_STATUS: n_state = B_STAT;
                        OP_PAY:    n_state = B_PAY;
                        default:   n_state = B_READ;
                    endcase
                end
            end
            B_READ: begin
                if (r_k < r_cmd.n) begin
                    rd_issue = 1'b1;
                    n_k = r_k + 3'd1;
                end else if (!r_rd_vld) begin
                    n_state = B_FRAME;
                end
            end
            B_FRAME: begin
                if (free) begin
                    load = 1'b1;
                    n_res.kind = KIND_FRAME;
                    n_res.tx_id = i_tester_id;
                    n_res.tx_dlc = 4'd8;
                    n_res.tx_data = r_frame;
                    n_res.gap_us = r_cmd.gap;
                    n_res.last = 1'b1;
                    n_state = B_IDLE;
                end
            end
            B_PAY: begin
                if (free) begin
                    load = 1'b1;
                    n_res.kind = KIND_PAYLOAD;
                    n_res.payload_byte = r_cmd.data[63 - 8*pidx -: 8];
                    n_res.payload_end = r_cmd.has_end && (r_k == r_cmd.end_i);
                    n_res.payload_length = r_cmd.plen;
                    n_res.last = (r_k == r_cmd.n - 3'd1) && !r_cmd.ack;
                    n_k = r_k + 3'd1;
                    if (r_k == r_cmd.n - 3'd1) begin
                        n_state = r_cmd.ack ? B_ACK : B_IDLE;
                    end
                end
            end
            B_ACK: begin
                if (free) begin
                    load = 1'b1;
                    n_res.kind = KIND_FRAME;
                    n_res.tx_id = i_tester_id;
                    n_res.tx_dlc = r_cmd.ack_dlc;
                    n_res.tx_data = {8'h30, 56'd0};
                    n_res.last = 1'b1;
                    n_state = B_IDLE;
                end
            end
            B_STAT: begin
                if (free) begin
                    load = 1'b1;
                    n_res.kind = KIND_STATUS;
                    n_res.status = r_cmd.status;
                    n_res.last = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_frame <= init_frame;
        end else if (r_rd_vld) begin
            r_frame[63 - 8*r_rd_slot -: 8] <= i_rdata;
        end
        r_rd_slot <= r_k + ((r_cmd.op == OP_FF) ? 3'd2 : 3'd1);
        if (load) begin
            o_result <= n_res;
        end
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k <= '0;
            r_rd_vld <= 1'b0;
            r_prev <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k <= n_k;
            r_rd_vld <= rd_issue;
            // first and consecutive frames leave their bytes as padding for the next one
            if (r_state == B_FRAME && free && r_cmd.op != OP_SF) begin
                r_prev <= r_frame;
            end
            if (load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/cstr_checker.sv
// port-level checks on the result channel, bound to the top level
`default_nettype none
module cstr_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_stall,
    input  wire cstr_pkg::t_out_item o_out_item
);
    import cstr_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_frame_dlc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_FRAME |->
        (o_out_item.tx_dlc == 4'd8 || o_out_item.tx_dlc == 4'd3))
        else $error("bad frame byte count");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_STATUS |->
        (o_out_item.last && o_out_item.status != ST_OK))
        else $error("status word malformed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind can_transport_segment_reassemble cstr_checker u_cstr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
